FILE: rtl/rwcc_pkg.sv
// Shared constants and types for the route window and capacity checker.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package rwcc_pkg;

    // default parameter values
    localparam int COORD_BITS_DEF = 12;
    localparam int TIME_BITS_DEF  = 24;

    // fixed field widths
    localparam int COORD_W  = 12;
    localparam int WIN_W    = 20;
    localparam int SERV_W   = 16;
    localparam int DEM_W    = 10;
    localparam int LEN_W    = 24;
    localparam int LOAD_W   = 17;
    localparam int LIMIT_W  = 16;
    localparam int DUE_W    = 20;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    localparam cfg_idx_t REG_DEPOT_X    = 2'd0;
    localparam cfg_idx_t REG_DEPOT_Y    = 2'd1;
    localparam cfg_idx_t REG_DEPOT_DUE  = 2'd2;
    localparam cfg_idx_t REG_LOAD_LIMIT = 2'd3;

    localparam logic [DUE_W-1:0]   DUE_RESET        = 20'hFFFFF;
    localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RESET = 16'd200;

    localparam logic [LEN_W-1:0]  LEN_MAX  = 24'hFFFFFF;
    localparam logic [LOAD_W-1:0] LOAD_MAX = 17'h1FFFF;

endpackage

FILE: rtl/rwcc_if.sv
// Handshake channels of the checker: stop words in, result words out.
// Depends on rwcc_pkg for the field widths.
`timescale 1ns / 1ps

interface rwcc_stop_if;
    logic                            valid;
    logic                            ready;
    logic [rwcc_pkg::COORD_W-1:0]    stop_x;
    logic [rwcc_pkg::COORD_W-1:0]    stop_y;
    logic [rwcc_pkg::WIN_W-1:0]      window_open;
    logic [rwcc_pkg::WIN_W-1:0]      window_close;
    logic [rwcc_pkg::SERV_W-1:0]     service_duration;
    logic [rwcc_pkg::DEM_W-1:0]      stop_demand;
    logic                            final_stop;

    modport source
    (
        output valid, stop_x, stop_y, window_open, window_close,
               service_duration, stop_demand, final_stop,
        input  ready
    );

    modport sink
    (
        input  valid, stop_x, stop_y, window_open, window_close,
               service_duration, stop_demand, final_stop,
        output ready
    );
endinterface

interface rwcc_result_if;
    logic                            valid;
    logic                            ready;
    logic                            time_feasible;
    logic                            load_feasible;
    logic [rwcc_pkg::LEN_W-1:0]      route_length;
    logic [rwcc_pkg::LEN_W-1:0]      return_time;

    modport source
    (
        output valid, time_feasible, load_feasible, route_length, return_time,
        input  ready
    );

    modport sink
    (
        input  valid, time_feasible, load_feasible, route_length, return_time,
        output ready
    );
endinterface

FILE: rtl/rwcc_leg_len.sv
// Leg length unit: floor of the Euclidean distance between two points.
// Squares in one step, then a restoring square root one result bit per cycle.
// Depends on rwcc_pkg.
`timescale 1ns / 1ps

module rwcc_leg_len #(
    parameter int COORD_BITS = rwcc_pkg::COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [COORD_BITS-1:0] ax,
    input  logic [COORD_BITS-1:0] ay,
    input  logic [COORD_BITS-1:0] bx,
    input  logic [COORD_BITS-1:0] by,
    output logic                  done,
    output logic [COORD_BITS:0]   len
);

    localparam int SQW   = 2 * COORD_BITS;
    localparam int VW    = 2 * COORD_BITS + 2;
    localparam int RW    = COORD_BITS + 2;
    localparam int ITER  = COORD_BITS + 1;
    localparam int CNT_W = $clog2(ITER);

    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_SQ   = 2'd1;
    localparam logic [1:0] L_LOAD = 2'd2;
    localparam logic [1:0] L_ROOT = 2'd3;

    logic [1:0]            phase_reg;
    logic                  done_reg;
    logic [COORD_BITS-1:0] dx_reg;
    logic [COORD_BITS-1:0] dy_reg;
    logic [SQW-1:0]        sqx_reg;
    logic [SQW-1:0]        sqy_reg;
    logic [VW-1:0]         v_reg;
    logic [RW-1:0]         rem_reg;
    logic [COORD_BITS:0]   root_reg;
    logic [CNT_W-1:0]      cnt_reg;

    logic [RW+1:0]         rem_sh;
    logic [RW:0]           trial;
    logic                  ge;
    logic [RW+1:0]         rem_sub;

    // one root bit per step: bring down two operand bits, try 4*root+1
    assign rem_sh  = {rem_reg, v_reg[VW-1 -: 2]};
    assign trial   = {root_reg, 2'b01};
    assign ge      = rem_sh >= {1'b0, trial};
    assign rem_sub = rem_sh - {1'b0, trial};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (phase_reg)
                L_IDLE:
                begin
                    if (start)
                    begin
                        phase_reg <= L_SQ;
                    end
                end
                L_SQ:
                begin
                    phase_reg <= L_LOAD;
                end
                L_LOAD:
                begin
                    phase_reg <= L_ROOT;
                end
                L_ROOT:
                begin
                    if (cnt_reg == '0)
                    begin
                        phase_reg <= L_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    phase_reg <= L_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (phase_reg)
            L_IDLE:
            begin
                if (start)
                begin
                    dx_reg <= (ax >= bx) ? (ax - bx) : (bx - ax);
                    dy_reg <= (ay >= by) ? (ay - by) : (by - ay);
                end
            end
            L_SQ:
            begin
                sqx_reg <= SQW'(dx_reg) * SQW'(dx_reg);
                sqy_reg <= SQW'(dy_reg) * SQW'(dy_reg);
            end
            L_LOAD:
            begin
                v_reg    <= VW'(sqx_reg) + VW'(sqy_reg);
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= CNT_W'(ITER - 1);
            end
            L_ROOT:
            begin
                rem_reg  <= ge ? rem_sub[RW-1:0] : rem_sh[RW-1:0];
                root_reg <= {root_reg[COORD_BITS-1:0], ge};
                v_reg    <= {v_reg[VW-3:0], 2'b00};
                cnt_reg  <= cnt_reg - CNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    assign done = done_reg;
    assign len  = root_reg;

endmodule

FILE: rtl/route_window_capacity_checker.sv
// Route checker: per stop one leg length, then arrival, wait and service timing.
// A non-final stop is taken in, its leg measured and its departure set before ready rises again;
// a final stop also measures the return leg to the depot before its result word is shown.
// Leg lengths come from a bit-serial square root, one root bit per cycle.
// A finished result waits in an output register while the next stop is taken in.
// Reset (rst_n, async, active low) clears route state and loads register defaults.
`timescale 1ns / 1ps

module route_window_capacity_checker #(
    parameter int COORD_BITS = rwcc_pkg::COORD_BITS_DEF,
    parameter int TIME_BITS  = rwcc_pkg::TIME_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    rwcc_stop_if.sink           stop,
    rwcc_result_if.source       result,
    input  logic                cfg_we,
    input  rwcc_pkg::cfg_idx_t  cfg_index,
    input  rwcc_pkg::cfg_data_t cfg_wdata
);

    localparam int LEN_W  = rwcc_pkg::LEN_W;
    localparam int LOAD_W = rwcc_pkg::LOAD_W;
    localparam int SUM_W  = (TIME_BITS > LEN_W ? TIME_BITS : LEN_W) + 1;

    localparam logic [SUM_W-1:0] TIME_MAX = {{(SUM_W-TIME_BITS){1'b0}}, {TIME_BITS{1'b1}}};
    localparam logic [SUM_W-1:0] RET_MAX  = {{(SUM_W-LEN_W){1'b0}}, rwcc_pkg::LEN_MAX};

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LEG1   = 3'd1;
    localparam logic [2:0] S_DEPART = 3'd2;
    localparam logic [2:0] S_LEG2   = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    // configuration
    logic [rwcc_pkg::COORD_W-1:0] depot_x_reg;
    logic [rwcc_pkg::COORD_W-1:0] depot_y_reg;
    logic [rwcc_pkg::DUE_W-1:0]   due_reg;
    logic [rwcc_pkg::LIMIT_W-1:0] limit_reg;

    // control and route state
    logic [2:0]                   state_reg;
    logic                         route_start_reg;
    logic                         late_reg;
    logic [TIME_BITS-1:0]         depart_reg;
    logic [LOAD_W-1:0]            load_reg;
    logic [LEN_W-1:0]             length_reg;
    logic                         out_valid_reg;

    // per stop payload
    logic [COORD_BITS-1:0]        prev_x_reg;
    logic [COORD_BITS-1:0]        prev_y_reg;
    logic [rwcc_pkg::WIN_W-1:0]   open_reg;
    logic [rwcc_pkg::WIN_W-1:0]   close_reg;
    logic [rwcc_pkg::SERV_W-1:0]  serv_reg;
    logic [rwcc_pkg::DEM_W-1:0]   dem_reg;
    logic                         fin_reg;
    logic [TIME_BITS-1:0]         arrive_reg;
    logic [TIME_BITS-1:0]         ret_reg;

    // result word
    logic                         time_ok_reg;
    logic                         load_ok_reg;
    logic [LEN_W-1:0]             length_out_reg;
    logic [LEN_W-1:0]             ret_out_reg;

    logic                         stop_acc;
    logic                         out_load;
    logic                         leg_start;
    logic                         leg_done;
    logic [COORD_BITS:0]          leg_len;
    logic [COORD_BITS-1:0]        depot_xc;
    logic [COORD_BITS-1:0]        depot_yc;
    logic [COORD_BITS-1:0]        leg_ax;
    logic [COORD_BITS-1:0]        leg_ay;
    logic [COORD_BITS-1:0]        leg_bx;
    logic [COORD_BITS-1:0]        leg_by;

    logic [LEN_W:0]               len_sum;
    logic [LEN_W-1:0]             len_sat;
    logic [SUM_W-1:0]             time_leg;
    logic [SUM_W-1:0]             time_leg_sat;
    logic [LOAD_W:0]              load_sum;
    logic [LOAD_W-1:0]            load_sat;
    logic [SUM_W-1:0]             arr_ext;
    logic                         early;
    logic                         late_now;
    logic [SUM_W-1:0]             dep_sum;
    logic [SUM_W-1:0]             dep_sat;
    logic [SUM_W-1:0]             ret_ext;

    assign stop.ready = (state_reg == S_IDLE);
    assign stop_acc   = stop.valid && stop.ready;
    assign out_load   = (state_reg == S_OUT) && (!out_valid_reg || result.ready);

    assign depot_xc = COORD_BITS'(depot_x_reg);
    assign depot_yc = COORD_BITS'(depot_y_reg);

    // outbound leg from the previous point (depot on a new route); return leg to the depot
    assign leg_ax    = (state_reg == S_IDLE && route_start_reg) ? depot_xc : prev_x_reg;
    assign leg_ay    = (state_reg == S_IDLE && route_start_reg) ? depot_yc : prev_y_reg;
    assign leg_bx    = (state_reg == S_IDLE) ? COORD_BITS'(stop.stop_x) : depot_xc;
    assign leg_by    = (state_reg == S_IDLE) ? COORD_BITS'(stop.stop_y) : depot_yc;
    assign leg_start = stop_acc || (state_reg == S_DEPART && fin_reg);

    rwcc_leg_len #(
        .COORD_BITS (COORD_BITS)
    ) u_leg (
        .clk   (clk),
        .rst_n (rst_n),
        .start (leg_start),
        .ax    (leg_ax),
        .ay    (leg_ay),
        .bx    (leg_bx),
        .by    (leg_by),
        .done  (leg_done),
        .len   (leg_len)
    );

    always_comb
    begin
        len_sum      = (LEN_W+1)'(length_reg) + (LEN_W+1)'(leg_len);
        len_sat      = len_sum[LEN_W] ? rwcc_pkg::LEN_MAX : len_sum[LEN_W-1:0];
        time_leg     = SUM_W'(depart_reg) + SUM_W'(leg_len);
        time_leg_sat = (time_leg > TIME_MAX) ? TIME_MAX : time_leg;
        load_sum     = (LOAD_W+1)'(load_reg) + (LOAD_W+1)'(dem_reg);
        load_sat     = load_sum[LOAD_W] ? rwcc_pkg::LOAD_MAX : load_sum[LOAD_W-1:0];

        // wait for the window if early; lateness is judged on the arrival itself
        arr_ext  = SUM_W'(arrive_reg);
        early    = arr_ext < SUM_W'(open_reg);
        late_now = !early && (arr_ext > SUM_W'(close_reg));
        dep_sum  = early ? (SUM_W'(open_reg) + SUM_W'(serv_reg))
                         : (arr_ext + SUM_W'(serv_reg));
        dep_sat  = (dep_sum > TIME_MAX) ? TIME_MAX : dep_sum;

        ret_ext  = SUM_W'(ret_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depot_x_reg <= '0;
            depot_y_reg <= '0;
            due_reg     <= rwcc_pkg::DUE_RESET;
            limit_reg   <= rwcc_pkg::LOAD_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rwcc_pkg::REG_DEPOT_X:    depot_x_reg <= cfg_wdata[rwcc_pkg::COORD_W-1:0];
                rwcc_pkg::REG_DEPOT_Y:    depot_y_reg <= cfg_wdata[rwcc_pkg::COORD_W-1:0];
                rwcc_pkg::REG_DEPOT_DUE:  due_reg     <= cfg_wdata[rwcc_pkg::DUE_W-1:0];
                rwcc_pkg::REG_LOAD_LIMIT: limit_reg   <= cfg_wdata[rwcc_pkg::LIMIT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            route_start_reg <= 1'b1;
            late_reg        <= 1'b0;
            depart_reg      <= '0;
            load_reg        <= '0;
            length_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (stop_acc)
                    begin
                        route_start_reg <= 1'b0;
                        state_reg       <= S_LEG1;
                    end
                end
                S_LEG1:
                begin
                    if (leg_done)
                    begin
                        length_reg <= len_sat;
                        load_reg   <= load_sat;
                        state_reg  <= S_DEPART;
                    end
                end
                S_DEPART:
                begin
                    depart_reg <= TIME_BITS'(dep_sat);
                    if (late_now)
                    begin
                        late_reg <= 1'b1;
                    end
                    state_reg <= fin_reg ? S_LEG2 : S_IDLE;
                end
                S_LEG2:
                begin
                    if (leg_done)
                    begin
                        length_reg <= len_sat;
                        state_reg  <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        route_start_reg <= 1'b1;
                        late_reg        <= 1'b0;
                        depart_reg      <= '0;
                        load_reg        <= '0;
                        length_reg      <= '0;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (stop_acc)
        begin
            prev_x_reg <= COORD_BITS'(stop.stop_x);
            prev_y_reg <= COORD_BITS'(stop.stop_y);
            open_reg   <= stop.window_open;
            close_reg  <= stop.window_close;
            serv_reg   <= stop.service_duration;
            dem_reg    <= stop.stop_demand;
            fin_reg    <= stop.final_stop;
        end
        if (state_reg == S_LEG1 && leg_done)
        begin
            arrive_reg <= TIME_BITS'(time_leg_sat);
        end
        if (state_reg == S_LEG2 && leg_done)
        begin
            ret_reg <= TIME_BITS'(time_leg_sat);
        end
        if (out_load)
        begin
            time_ok_reg    <= !late_reg && (ret_ext <= SUM_W'(due_reg));
            load_ok_reg    <= load_reg <= LOAD_W'(limit_reg);
            length_out_reg <= length_reg;
            ret_out_reg    <= (ret_ext > RET_MAX) ? rwcc_pkg::LEN_MAX : ret_ext[LEN_W-1:0];
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.time_feasible = time_ok_reg;
    assign result.load_feasible = load_ok_reg;
    assign result.route_length  = length_out_reg;
    assign result.return_time   = ret_out_reg;

`ifndef SYNTHESIS
    a_leg_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        leg_done |-> (state_reg == S_LEG1 || state_reg == S_LEG2))
        else $error("leg length finished with no leg outstanding");

    a_result_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result word raised outside the output state");

    a_route_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (route_start_reg && !late_reg && load_reg == '0 && length_reg == '0))
        else $error("route state not cleared after result word");

    a_late_only_on_depart: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(late_reg) |-> $past(state_reg) == S_DEPART)
        else $error("late flag set outside departure update");

    a_no_stop_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        stop_acc |=> (state_reg == S_LEG1))
        else $error("stop word taken without starting a leg");
`endif

endmodule

FILE: dv/route_window_capacity_checker_test.sv
// Self-checking bench for route_window_capacity_checker: stop words in, route results out.
// Depends on rwcc_pkg and the stop/result channel interfaces from the rtl folder.
`timescale 1ns / 1ps

module route_window_capacity_checker_test;

    localparam int COORD_W    = rwcc_pkg::COORD_W;
    localparam int WIN_W      = rwcc_pkg::WIN_W;
    localparam int SERV_W     = rwcc_pkg::SERV_W;
    localparam int DEM_W      = rwcc_pkg::DEM_W;
    localparam int LEN_W      = rwcc_pkg::LEN_W;
    localparam int DUE_W      = rwcc_pkg::DUE_W;
    localparam int LIMIT_W    = rwcc_pkg::LIMIT_W;
    localparam int CFG_DATA_W = rwcc_pkg::CFG_DATA_W;
    localparam logic [LEN_W-1:0]           LEN_MAX  = rwcc_pkg::LEN_MAX;
    localparam logic [rwcc_pkg::LOAD_W-1:0] LOAD_MAX = rwcc_pkg::LOAD_MAX;

    localparam int TIME_BITS = rwcc_pkg::TIME_BITS_DEF;
    localparam longint unsigned TIME_CEIL = (64'd1 << TIME_BITS) - 1;
    localparam int WIN_MAX = (1 << WIN_W) - 1;
    localparam int unsigned CYCLE_LIMIT = 1_500_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HAUL_STOPS = 260;

    typedef struct packed {
        logic [COORD_W-1:0] stop_x;
        logic [COORD_W-1:0] stop_y;
        logic [WIN_W-1:0]   window_open;
        logic [WIN_W-1:0]   window_close;
        logic [SERV_W-1:0]  service_duration;
        logic [DEM_W-1:0]   stop_demand;
        logic               final_stop;
    } stop_word_t;

    typedef struct packed {
        logic             time_feasible;
        logic             load_feasible;
        logic [LEN_W-1:0] route_length;
        logic [LEN_W-1:0] return_time;
    } route_result_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    rwcc_pkg::cfg_idx_t  cfg_index;
    rwcc_pkg::cfg_data_t cfg_wdata;

    rwcc_stop_if   stop_ch();
    rwcc_result_if result_ch();

    route_window_capacity_checker dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .stop      (stop_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // register copies held by the predictor
    logic [COORD_W-1:0] depot_x_r = '0;
    logic [COORD_W-1:0] depot_y_r = '0;
    logic [DUE_W-1:0]   due_r     = rwcc_pkg::DUE_RESET;
    logic [LIMIT_W-1:0] limit_r   = rwcc_pkg::LOAD_LIMIT_RESET;

    // route state of the predictor
    logic [COORD_W-1:0] cur_x = '0;
    logic [COORD_W-1:0] cur_y = '0;
    longint unsigned    clock_now = 0;
    longint unsigned    load_acc = 0;
    longint unsigned    dist_acc = 0;
    bit                 missed_window = 1'b0;
    bit                 route_fresh = 1'b1;

    stop_word_t    pending_stops[$];
    route_result_t expected_routes[$];
    stop_word_t    word_on_bus;

    int          send_idle_pct;
    int          recv_idle_pct;
    int          est_time = 0;
    int          stops_queued = 0;
    int          stops_sent = 0;
    int          routes_checked = 0;
    int          reg_writes = 0;
    int          mismatches = 0;
    int unsigned cycle_count = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b,
                                                longint unsigned lim);
        longint unsigned s;
        s = a + b;
        return (s > lim) ? lim : s;
    endfunction

    // floor of the Euclidean distance, one root bit at a time
    function automatic longint unsigned leg_length(logic [COORD_W-1:0] ax,
                                                   logic [COORD_W-1:0] ay,
                                                   logic [COORD_W-1:0] bx,
                                                   logic [COORD_W-1:0] by);
        longint unsigned dx, dy, sq, root, trial;
        dx = (ax > bx) ? ax - bx : bx - ax;
        dy = (ay > by) ? ay - by : by - ay;
        sq = dx * dx + dy * dy;
        root = 0;
        for (int b = 13; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= sq)
                root = trial;
        end
        return root;
    endfunction

    function automatic int clamp_window(int v);
        if (v < 0)
            return 0;
        if (v > WIN_MAX)
            return WIN_MAX;
        return v;
    endfunction

    // advance the route by one accepted stop; a final stop yields one expected result
    task automatic advance_route(stop_word_t w);
        longint unsigned leg, arrival, back, ret;
        route_result_t   r;
        if (route_fresh)
        begin
            cur_x = depot_x_r;
            cur_y = depot_y_r;
            route_fresh = 1'b0;
        end
        leg = leg_length(cur_x, cur_y, w.stop_x, w.stop_y);
        dist_acc = sat_sum(dist_acc, leg, LEN_MAX);
        arrival = sat_sum(clock_now, leg, TIME_CEIL);
        if (arrival < w.window_open)
            clock_now = sat_sum(w.window_open, w.service_duration, TIME_CEIL);
        else
        begin
            if (arrival > w.window_close)
                missed_window = 1'b1;
            clock_now = sat_sum(arrival, w.service_duration, TIME_CEIL);
        end
        load_acc = sat_sum(load_acc, w.stop_demand, LOAD_MAX);
        cur_x = w.stop_x;
        cur_y = w.stop_y;
        if (w.final_stop)
        begin
            back = leg_length(w.stop_x, w.stop_y, depot_x_r, depot_y_r);
            dist_acc = sat_sum(dist_acc, back, LEN_MAX);
            ret = sat_sum(clock_now, back, TIME_CEIL);
            r.time_feasible = !missed_window && (ret <= due_r);
            r.load_feasible = (load_acc <= limit_r);
            r.route_length = LEN_W'(dist_acc);
            r.return_time = (ret > LEN_MAX) ? LEN_MAX : LEN_W'(ret);
            expected_routes = {expected_routes, r};
            cur_x = '0;
            cur_y = '0;
            clock_now = 0;
            load_acc = 0;
            dist_acc = 0;
            missed_window = 1'b0;
            route_fresh = 1'b1;
        end
    endtask

    task automatic queue_stop(int x, int y, int open_t, int close_t, int serv, int dem,
                              bit last);
        stop_word_t w;
        w.stop_x = COORD_W'(x);
        w.stop_y = COORD_W'(y);
        w.window_open = WIN_W'(open_t);
        w.window_close = WIN_W'(close_t);
        w.service_duration = SERV_W'(serv);
        w.stop_demand = DEM_W'(dem);
        w.final_stop = last;
        pending_stops = {pending_stops, w};
        stops_queued++;
    endtask

    // mostly windows placed around a rough arrival estimate, sometimes raw noise
    task automatic add_stop(bit last);
        int x, y, open_t, close_t, serv, dem;
        x = $urandom_range(4095);
        y = $urandom_range(4095);
        if ($urandom_range(9) < 8)
        begin
            est_time = est_time + 1500 + int'($urandom_range(1000));
            open_t = clamp_window(est_time - 3000 + int'($urandom_range(6000)));
            close_t = clamp_window(open_t - 1000 + int'($urandom_range(12000)));
            serv = $urandom_range(400);
            dem = $urandom_range(70);
            if (open_t > est_time)
                est_time = open_t;
            est_time = est_time + serv;
        end
        else
        begin
            open_t = $urandom_range(WIN_MAX);
            close_t = $urandom_range(WIN_MAX);
            serv = $urandom_range(65535);
            dem = $urandom_range(1023);
        end
        queue_stop(x, y, open_t, close_t, serv, dem, last);
    endtask

    task automatic queue_route(int n, bit closes);
        for (int i = 0; i < n; i++)
            add_stop(closes && (i == n - 1));
        if (closes)
            est_time = 0;
    endtask

    task automatic queue_random_routes(int target);
        int start;
        start = stops_queued;
        while (stops_queued - start < target)
        begin
            if ($urandom_range(9) == 0)
                queue_route($urandom_range(20, 9), 1'b1);
            else
                queue_route($urandom_range(6, 1), 1'b1);
        end
    endtask

    task automatic write_reg(rwcc_pkg::cfg_idx_t idx, int value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        case (idx)
            rwcc_pkg::REG_DEPOT_X:    depot_x_r = COORD_W'(value);
            rwcc_pkg::REG_DEPOT_Y:    depot_y_r = COORD_W'(value);
            rwcc_pkg::REG_DEPOT_DUE:  due_r = DUE_W'(value);
            rwcc_pkg::REG_LOAD_LIMIT: limit_r = LIMIT_W'(value);
            default:                  ;
        endcase
        reg_writes++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // sender holds off until the block has returned every outstanding result
    task automatic wait_route_idle();
        do
            @(negedge clk);
        while (pending_stops.size() != 0 || stop_ch.valid || expected_routes.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // stop driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stop_ch.valid && stop_ch.ready)
            begin
                advance_route(word_on_bus);
                stops_sent++;
            end
            if (!stop_ch.valid || stop_ch.ready)
            begin
                if (pending_stops.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    word_on_bus = pending_stops.pop_front();
                    stop_ch.stop_x <= word_on_bus.stop_x;
                    stop_ch.stop_y <= word_on_bus.stop_y;
                    stop_ch.window_open <= word_on_bus.window_open;
                    stop_ch.window_close <= word_on_bus.window_close;
                    stop_ch.service_duration <= word_on_bus.service_duration;
                    stop_ch.stop_demand <= word_on_bus.stop_demand;
                    stop_ch.final_stop <= word_on_bus.final_stop;
                    stop_ch.valid <= 1'b1;
                end
                else
                    stop_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        route_result_t exp_r;
        route_result_t got_r;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got_r.time_feasible = result_ch.time_feasible;
                got_r.load_feasible = result_ch.load_feasible;
                got_r.route_length = result_ch.route_length;
                got_r.return_time = result_ch.return_time;
                if (expected_routes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result word: tf=%0b lf=%0b len=%0d ret=%0d",
                                 $time, got_r.time_feasible, got_r.load_feasible,
                                 got_r.route_length, got_r.return_time);
                end
                else
                begin
                    exp_r = expected_routes.pop_front();
                    routes_checked++;
                    if (got_r.time_feasible !== exp_r.time_feasible
                        || got_r.load_feasible !== exp_r.load_feasible
                        || got_r.route_length !== exp_r.route_length
                        || got_r.return_time !== exp_r.return_time)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: route %0d mismatch: exp tf=%0b lf=%0b len=%0d ret=%0d",
                                     $time, routes_checked, exp_r.time_feasible,
                                     exp_r.load_feasible, exp_r.route_length,
                                     exp_r.return_time);
                            $display("    got tf=%0b lf=%0b len=%0d ret=%0d",
                                     got_r.time_feasible, got_r.load_feasible,
                                     got_r.route_length, got_r.return_time);
                        end
                    end
                end
            end
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timed out after %0d cycles, %0d results still due",
                 cycle_count, expected_routes.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        stop_ch.valid = 1'b0;
        stop_ch.stop_x = '0;
        stop_ch.stop_y = '0;
        stop_ch.window_open = '0;
        stop_ch.window_close = '0;
        stop_ch.service_duration = '0;
        stop_ch.stop_demand = '0;
        stop_ch.final_stop = 1'b0;
        result_ch.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = rwcc_pkg::REG_DEPOT_X;
        cfg_wdata = '0;
        rst_n = 1'b0;
        send_idle_pct = 25;
        recv_idle_pct = 54;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed routes at reset register values
        queue_stop(0, 0, 0, 0, 0, 0, 1'b1);
        queue_stop(4095, 4095, WIN_MAX, WIN_MAX, 65535, 1023, 1'b1);
        // late at the first window, timing carries on from the arrival
        queue_stop(4095, 0, 0, 0, 7, 5, 1'b0);
        queue_stop(0, 4095, 0, WIN_MAX, 0, 0, 1'b1);
        // open after close: early arrival waits and is not late, later one is
        queue_stop(3, 4, 5000, 100, 0, 100, 1'b0);
        queue_stop(0, 0, 100, 50, 0, 100, 1'b1);
        // load right at the limit, then one over
        queue_stop(10, 20, 0, WIN_MAX, 1, 200, 1'b1);
        queue_stop(10, 20, 0, WIN_MAX, 1, 201, 1'b1);
        queue_stop(7, 7, 0, WIN_MAX, 3, 67, 1'b0);
        queue_stop(9, 2, 0, WIN_MAX, 3, 67, 1'b0);
        queue_stop(1, 8, 0, WIN_MAX, 3, 67, 1'b1);
        wait_route_idle();

        // return time on the due time, then one past it
        write_reg(rwcc_pkg::REG_DEPOT_X, 100);
        write_reg(rwcc_pkg::REG_DEPOT_Y, 100);
        write_reg(rwcc_pkg::REG_DEPOT_DUE, 20);
        queue_stop(103, 104, 0, WIN_MAX, 10, 0, 1'b1);
        queue_stop(103, 104, 0, WIN_MAX, 11, 0, 1'b1);
        wait_route_idle();

        write_reg(rwcc_pkg::REG_DEPOT_X, 4095);
        write_reg(rwcc_pkg::REG_DEPOT_Y, 4095);
        write_reg(rwcc_pkg::REG_DEPOT_DUE, WIN_MAX);
        write_reg(rwcc_pkg::REG_LOAD_LIMIT, 65535);
        queue_random_routes(180);
        // leave a route open so the depot moves under it
        queue_route(2, 1'b0);
        wait_route_idle();

        send_idle_pct = 54;
        recv_idle_pct = 25;
        write_reg(rwcc_pkg::REG_DEPOT_X, $urandom_range(4095));
        write_reg(rwcc_pkg::REG_DEPOT_Y, $urandom_range(4095));
        write_reg(rwcc_pkg::REG_DEPOT_DUE, $urandom_range(WIN_MAX, 200000));
        write_reg(rwcc_pkg::REG_LOAD_LIMIT, $urandom_range(1500, 100));
        queue_route(2, 1'b1);
        queue_random_routes(180);
        queue_route(3, 1'b0);
        wait_route_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(rwcc_pkg::REG_DEPOT_X, 0);
        write_reg(rwcc_pkg::REG_DEPOT_Y, 0);
        write_reg(rwcc_pkg::REG_DEPOT_DUE, 0);
        write_reg(rwcc_pkg::REG_LOAD_LIMIT, 0);
        queue_random_routes(20);
        wait_route_idle();

        write_reg(rwcc_pkg::REG_DEPOT_X, $urandom_range(4095));
        write_reg(rwcc_pkg::REG_DEPOT_Y, $urandom_range(4095));
        write_reg(rwcc_pkg::REG_DEPOT_DUE, $urandom_range(WIN_MAX, 400000));
        write_reg(rwcc_pkg::REG_LOAD_LIMIT, 300);
        // corner to corner haul: time and load both saturate
        for (int i = 0; i < HAUL_STOPS; i++)
            queue_stop((i % 2 == 0) ? 4095 : 0, (i % 2 == 0) ? 4095 : 0,
                       $urandom_range(WIN_MAX), $urandom_range(WIN_MAX), 65535, 1023,
                       i == HAUL_STOPS - 1);
        queue_random_routes(180);
        wait_route_idle();

        if (expected_routes.size() != 0)
        begin
            mismatches += expected_routes.size();
            $display("%0d expected results never arrived", expected_routes.size());
        end
        $display("Ran %0d stop words through %0d checked routes, %0d register writes,",
                 stops_sent, routes_checked, reg_writes);
        $display("three idling mixes, depot moves mid-route, saturating time and load");
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: route_window_capacity_checker.f
rtl/rwcc_pkg.sv
rtl/rwcc_if.sv
rtl/rwcc_leg_len.sv
rtl/route_window_capacity_checker.sv
dv/route_window_capacity_checker_test.sv
